### design/klein64_block_cipher_unit_macros.svh
// Assertion macros shared by the checker of klein64_block_cipher_unit.
// All assertions sample on the rising edge of clock.
`ifndef KLEIN64_BLOCK_CIPHER_UNIT_MACROS_SVH
`define KLEIN64_BLOCK_CIPHER_UNIT_MACROS_SVH

// Check that cons follows ante after the delay given by dly; drop the attempt while rst is high.
`define KLEIN64_ASSERT_DLY(lbl, rst, ante, dly, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error(msg);

// Check cons in the cycle after ante, reset included.
`define KLEIN64_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/klein64_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package klein64_pkg;

   localparam int RoundCountDef = 12;

   localparam logic [3:0] SBOX [16] = '{
      4'h7, 4'h4, 4'hA, 4'h9, 4'h1, 4'hF, 4'hB, 4'h0,
      4'hC, 4'h3, 4'h2, 4'h6, 4'h8, 4'hE, 4'hD, 4'h5
   };

   localparam logic [7:0] GF_POLY = 8'h1B;

   function automatic logic [7:0] sbox8(input logic [7:0] b);
      return {SBOX[b[7:4]], SBOX[b[3:0]]};
   endfunction

   function automatic logic [63:0] sbox64(input logic [63:0] x);
      logic [63:0] r;
      r = '0;
      for (int n = 0; n < 16; n++) begin
         r[4*n +: 4] = SBOX[x[4*n +: 4]];
      end
      return r;
   endfunction

   function automatic logic [7:0] gf_dbl(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
   endfunction

   // AES MixColumn on four bytes, byte 0 most significant
   function automatic logic [31:0] mix_col(input logic [31:0] a);
      logic [7:0] a0, a1, a2, a3, sum;
      a0  = a[31:24];
      a1  = a[23:16];
      a2  = a[15:8];
      a3  = a[7:0];
      sum = a0 ^ a1 ^ a2 ^ a3;
      return {a0 ^ gf_dbl(a0 ^ a1) ^ sum,
              a1 ^ gf_dbl(a1 ^ a2) ^ sum,
              a2 ^ gf_dbl(a2 ^ a3) ^ sum,
              a3 ^ gf_dbl(a3 ^ a0) ^ sum};
   endfunction

   // Pre-multiplication that turns MixColumn into its inverse
   function automatic logic [31:0] inv_premix(input logic [31:0] a);
      logic [7:0] u, v;
      u = gf_dbl(gf_dbl(a[31:24] ^ a[15:8]));
      v = gf_dbl(gf_dbl(a[23:16] ^ a[7:0]));
      return a ^ {u, v, u, v};
   endfunction

   function automatic logic [63:0] enc_round(input logic [63:0] x, input logic [63:0] k);
      logic [63:0] t;
      t = sbox64(x ^ k);
      t = {t[47:0], t[63:48]};
      return {mix_col(t[63:32]), mix_col(t[31:0])};
   endfunction

   function automatic logic [63:0] dec_round(input logic [63:0] x, input logic [63:0] k);
      logic [63:0] t;
      t = {mix_col(inv_premix(x[63:32])), mix_col(inv_premix(x[31:0]))};
      t = sbox64(t);
      return {t[15:0], t[63:16]} ^ k;
   endfunction

   // One step of the key schedule, rc is the round counter of the new key
   function automatic logic [63:0] key_step(input logic [63:0] p, input logic [7:0] rc);
      logic [7:0] p0, p1, p2, p3, p4, p5, p6, p7;
      p0 = p[63:56];
      p1 = p[55:48];
      p2 = p[47:40];
      p3 = p[39:32];
      p4 = p[31:24];
      p5 = p[23:16];
      p6 = p[15:8];
      p7 = p[7:0];
      return {p5, p6, p7 ^ rc, p4, p1 ^ p5, sbox8(p2 ^ p6), sbox8(p3 ^ p7), p0 ^ p4};
   endfunction

endpackage

`default_nettype wire

### design/klein64_block_cipher_unit.sv
// Pipeline: a request accepted at a clock edge passes through the input register,
//   one register per round and the output register before its result strobe.
// Throughput: one request per cycle; busy is high only while the round keys rebuild.
// Reset: synchronous, active high; the key returns to zero and the round keys
//   rebuild (busy high), likewise after every key write.
// The receiver cannot stall; the pipeline never holds.
`timescale 1ns / 1ps
`default_nettype none

module klein64_block_cipher_unit
   import klein64_pkg::*;
#(
   parameter int ROUND_COUNT = RoundCountDef
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_func,
   input  wire logic [63:0] req_block_in,
   // result channel
   output logic             rsp_valid,
   output logic [63:0]      rsp_block_out,
   // key register
   input  wire logic        csr_we,
   input  wire logic [63:0] csr_wdata
);

   localparam int KeyCount = ROUND_COUNT + 1;
   localparam int CntW     = $clog2(KeyCount);
   localparam logic [CntW-1:0] LastIdx  = CntW'(ROUND_COUNT);
   localparam logic [CntW-1:0] FirstIdx = CntW'(1);

   // ---------------------------------------------------------------------
   // Key schedule sequencer: rebuild one round key per cycle after a key
   // write or reset. Entry 0 holds the key itself.
   // ---------------------------------------------------------------------
   logic            key_busy_ff;
   logic [CntW-1:0] key_cnt_ff;
   logic [63:0]     key_prev_ff;
   logic [63:0]     key_prev_in;
   logic [63:0]     rk_ff [KeyCount];

   assign key_prev_in = key_step(key_prev_ff, 8'(key_cnt_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         key_busy_ff <= 1'b1;
         key_cnt_ff  <= FirstIdx;
      end else if (csr_we) begin
         // restart the rebuild from the new key
         key_busy_ff <= 1'b1;
         key_cnt_ff  <= FirstIdx;
      end else if (key_busy_ff) begin
         if (key_cnt_ff == LastIdx) begin
            key_busy_ff <= 1'b0;
         end else begin
            key_cnt_ff <= key_cnt_ff + FirstIdx;
         end
      end
   end

   // Key storage: reset loads the all-zero key, then the sequencer fills the rest
   always_ff @(posedge clock) begin
      if (reset) begin
         key_prev_ff <= '0;
         rk_ff[0]    <= '0;
      end else if (csr_we) begin
         key_prev_ff <= csr_wdata;
         rk_ff[0]    <= csr_wdata;
      end else if (key_busy_ff) begin
         key_prev_ff        <= key_prev_in;
         rk_ff[key_cnt_ff]  <= key_prev_in;
      end
   end

   // Hold off requests while the round keys are incomplete
   assign busy = key_busy_ff;

   // ---------------------------------------------------------------------
   // Round pipeline: stage 0 is the input register, stage k+1 holds the
   // block after round k. Encryption uses round key k in round k; decryption
   // runs the keys backward, so its final-key whitening happens on entry and
   // encryption's happens at the output register.
   // ---------------------------------------------------------------------
   logic        req_take;
   logic        stg_valid_ff [ROUND_COUNT+1];
   logic        stg_func_ff  [ROUND_COUNT+1];
   logic [63:0] stg_data_ff  [ROUND_COUNT+1];
   logic [63:0] stg_data_in  [ROUND_COUNT+1];

   assign req_take       = start && !key_busy_ff;
   assign stg_data_in[0] = req_func ? (req_block_in ^ rk_ff[ROUND_COUNT]) : req_block_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff[0] <= 1'b0;
      end else begin
         stg_valid_ff[0] <= req_take;
      end
   end

   always_ff @(posedge clock) begin
      stg_func_ff[0] <= req_func;
      stg_data_ff[0] <= stg_data_in[0];
   end

   for (genvar k = 0; k < ROUND_COUNT; k++) begin : g_round
      // each round picks its fixed key slot by direction
      assign stg_data_in[k+1] = stg_func_ff[k]
         ? dec_round(stg_data_ff[k], rk_ff[ROUND_COUNT-1-k])
         : enc_round(stg_data_ff[k], rk_ff[k]);

      always_ff @(posedge clock) begin
         if (reset) begin
            stg_valid_ff[k+1] <= 1'b0;
         end else begin
            stg_valid_ff[k+1] <= stg_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         stg_func_ff[k+1] <= stg_func_ff[k];
         stg_data_ff[k+1] <= stg_data_in[k+1];
      end
   end

   // ---------------------------------------------------------------------
   // Output register: add the final round key for encryption, then strobe
   // the result for exactly one cycle.
   // ---------------------------------------------------------------------
   logic        rsp_valid_ff;
   logic [63:0] rsp_block_ff;
   logic [63:0] rsp_block_in;

   assign rsp_block_in = stg_func_ff[ROUND_COUNT]
      ? stg_data_ff[ROUND_COUNT]
      : (stg_data_ff[ROUND_COUNT] ^ rk_ff[ROUND_COUNT]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= stg_valid_ff[ROUND_COUNT];
      end
   end

   always_ff @(posedge clock) begin
      rsp_block_ff <= rsp_block_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_block_out = rsp_block_ff;

endmodule

`default_nettype wire

### design/klein64_chk.sv
`timescale 1ns / 1ps
`default_nettype none

`include "klein64_block_cipher_unit_macros.svh"

module klein64_chk
   import klein64_pkg::*;
#(
   parameter int ROUND_COUNT = RoundCountDef
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid,
   input wire logic csr_we
);

   localparam int Latency = ROUND_COUNT + 2;

   // reset and key writes both start a key rebuild
   `KLEIN64_ASSERT_NEXT(a_reset_busy, reset, busy, "busy low after reset")
   `KLEIN64_ASSERT_DLY(a_write_busy, reset, csr_we, 1, busy, "busy low after key write")
   // every accepted request yields a result at the fixed latency, and no other
   `KLEIN64_ASSERT_DLY(a_req_rsp, reset, start && !busy, Latency, rsp_valid, "result missing")
   `KLEIN64_ASSERT_DLY(a_rsp_req, reset, rsp_valid, 0, $past(start && !busy, Latency), "result without request")

endmodule

bind klein64_block_cipher_unit klein64_chk #(
   .ROUND_COUNT(ROUND_COUNT)
) u_klein64_chk (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .rsp_valid(rsp_valid),
   .csr_we   (csr_we)
);

`default_nettype wire

### sim/klein64_block_cipher_unit_test.sv
`timescale 1ns / 1ps

module klein64_block_cipher_unit_test;
   import klein64_pkg::*;

   localparam int Rounds        = RoundCountDef;
   localparam int IdleLimit     = 4000;
   localparam int RandomPhases  = 8;
   localparam int PhaseRequests = 100;

   localparam logic FUNC_ENCRYPT = 1'b0;
   localparam logic FUNC_DECRYPT = 1'b1;

   // 4-bit substitution, entry 0 in the top nibble
   localparam logic [63:0] NibbleSub = 64'h74A91FB0_C3268ED5;
   localparam logic [7:0]  FieldPoly = 8'h1B;

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        start        = 1'b0;
   logic        busy;
   logic        req_func     = 1'b0;
   logic [63:0] req_block_in = '0;
   logic        rsp_valid;
   logic [63:0] rsp_block_out;
   logic        csr_we       = 1'b0;
   logic [63:0] csr_wdata    = '0;

   // Shadow of the round key table, rebuilt on every key write
   logic [63:0] round_keys [Rounds+1];
   // Expected output blocks, oldest first
   logic [63:0] pending_blocks [$];
   logic [63:0] wanted_block;

   int mismatch_count = 0;
   int idle_cycles    = 0;
   // Set while start is being driven high, so it is lowered only once per step
   bit start_held     = 1'b0;

   // Last accepted request; its inverse is a well-formed follow-up request
   logic        last_func      = FUNC_ENCRYPT;
   logic [63:0] last_block_in  = '0;
   logic [63:0] last_block_out = '0;

   klein64_block_cipher_unit #(
      .ROUND_COUNT(Rounds)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_func     (req_func),
      .req_block_in (req_block_in),
      .rsp_valid    (rsp_valid),
      .rsp_block_out(rsp_block_out),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // Cipher predictor
   // ---------------------------------------------------------------

   // Byte i of a 64-bit word, byte 0 most significant
   function automatic logic [7:0] octet(input logic [63:0] w, input int i);
      return w[8*(7-i) +: 8];
   endfunction

   function automatic logic [7:0] sub_octet(input logic [7:0] b);
      return {NibbleSub[4*(15-b[7:4]) +: 4], NibbleSub[4*(15-b[3:0]) +: 4]};
   endfunction

   // Multiply by x in GF(2^8)
   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? FieldPoly : 8'h00);
   endfunction

   // Column mix of one 4-byte half
   function automatic logic [31:0] column_mix(input logic [31:0] a);
      logic [7:0]  c [4];
      logic [7:0]  total;
      logic [31:0] o;
      for (int k = 0; k < 4; k++) c[k] = a[8*(3-k) +: 8];
      total = c[0] ^ c[1] ^ c[2] ^ c[3];
      for (int k = 0; k < 4; k++) begin
         o[8*(3-k) +: 8] = c[k] ^ xtime(c[k] ^ c[(k+1)%4]) ^ total;
      end
      return o;
   endfunction

   // Rebuild the round keys; the round counter enters the new third byte
   function automatic void expand_key(input logic [63:0] key);
      logic [63:0] prev;
      logic [63:0] nxt;
      prev = key;
      round_keys[0] = key;
      for (int i = 1; i <= Rounds; i++) begin
         nxt = {octet(prev, 5),
                octet(prev, 6),
                octet(prev, 7) ^ 8'(i),
                octet(prev, 4),
                octet(prev, 1) ^ octet(prev, 5),
                sub_octet(octet(prev, 2) ^ octet(prev, 6)),
                sub_octet(octet(prev, 3) ^ octet(prev, 7)),
                octet(prev, 0) ^ octet(prev, 4)};
         round_keys[i] = nxt;
         prev = nxt;
      end
   endfunction

   function automatic logic [63:0] klein_encrypt(input logic [63:0] blk);
      logic [63:0] x;
      logic [63:0] t;
      x = blk;
      for (int r = 0; r < Rounds; r++) begin
         x = x ^ round_keys[r];
         // substitute and rotate left by two bytes in one pass
         for (int j = 0; j < 8; j++) t[8*(7-j) +: 8] = sub_octet(octet(x, (j+2)%8));
         x = {column_mix(t[63:32]), column_mix(t[31:0])};
      end
      return x ^ round_keys[Rounds];
   endfunction

   function automatic logic [63:0] klein_decrypt(input logic [63:0] blk);
      logic [63:0] x;
      logic [63:0] m;
      logic [63:0] s;
      logic [7:0]  u;
      logic [7:0]  v;
      x = blk ^ round_keys[Rounds];
      for (int r = Rounds; r > 0; r--) begin
         // pre-multiply each half so that the column mix inverts itself
         for (int h = 0; h < 2; h++) begin
            u = xtime(xtime(octet(x, 4*h) ^ octet(x, 4*h+2)));
            v = xtime(xtime(octet(x, 4*h+1) ^ octet(x, 4*h+3)));
            x[32*(1-h) +: 32] = x[32*(1-h) +: 32] ^ {u, v, u, v};
         end
         m = {column_mix(x[63:32]), column_mix(x[31:0])};
         // rotate right by two bytes, then substitute
         for (int j = 0; j < 8; j++) s[8*(7-((j+2)%8)) +: 8] = sub_octet(octet(m, j));
         x = s ^ round_keys[r-1];
      end
      return x;
   endfunction

   // ---------------------------------------------------------------
   // Shared driving tasks
   // ---------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // Drop start unless it is already low
   task automatic release_request();
      if (start_held) begin
         start <= 1'b0;
         start_held = 1'b0;
      end
   endtask

   // Drop start and idle when gap is nonzero, then hold the request until busy is low at an edge.
   // Leave start high on return so a back-to-back request keeps it up.
   task automatic send_request(input logic func, input logic [63:0] blk, input int gap);
      if (gap > 0) begin
         release_request();
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_func     <= func;
      req_block_in <= blk;
      start_held    = 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      last_func      = func;
      last_block_in  = blk;
      last_block_out = (func == FUNC_DECRYPT) ? klein_decrypt(blk) : klein_encrypt(blk);
      pending_blocks.push_back(last_block_out);
   endtask

   // Hold off new requests until every expected result has come back
   task automatic wait_drained();
      release_request();
      while (pending_blocks.size() != 0) @(posedge clock);
   endtask

   // Write the key; call only after wait_drained, and never twice in a row
   task automatic load_key(input logic [63:0] key);
      csr_we    <= 1'b1;
      csr_wdata <= key;
      @(posedge clock);
      csr_we    <= 1'b0;
      expand_key(key);
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Run with the all-zero key left by reset: field extremes, both functions
   task automatic test_reset_key();
      send_request(FUNC_ENCRYPT, 64'h0, 0);
      send_request(FUNC_ENCRYPT, '1, 0);
      send_request(FUNC_DECRYPT, 64'h0, 0);
      send_request(FUNC_DECRYPT, '1, 0);
      send_request(FUNC_ENCRYPT, 64'h0123_4567_89AB_CDEF, 2);
      // decrypt the ciphertext just produced
      send_request(~last_func, last_block_out, 0);
   endtask

   // All-ones, all-zero and alternating keys
   task automatic test_key_extremes();
      wait_drained();
      load_key('1);
      send_request(FUNC_ENCRYPT, 64'h0, 0);
      send_request(FUNC_DECRYPT, 64'h0, 1);
      send_request(FUNC_ENCRYPT, '1, 0);
      send_request(FUNC_DECRYPT, '1, 3);
      wait_drained();
      load_key(64'h0);
      send_request(FUNC_ENCRYPT, '1, 0);
      send_request(~last_func, last_block_out, 0);
      wait_drained();
      load_key(64'hAAAA_AAAA_AAAA_AAAA);
      send_request(FUNC_ENCRYPT, 64'h5555_5555_5555_5555, 0);
      send_request(~last_func, last_block_out, 0);
   endtask

   // A new key must apply to the very next request after the write
   task automatic test_key_change();
      wait_drained();
      load_key(64'h0123_4567_89AB_CDEF);
      send_request(FUNC_ENCRYPT, 64'hFEDC_BA98_7654_3210, 0);
      wait_drained();
      load_key(64'h8000_0000_0000_0001);
      send_request(FUNC_ENCRYPT, 64'hFEDC_BA98_7654_3210, 0);
      send_request(~last_func, last_block_out, 0);
   endtask

   // Phases of random traffic, each under its own key. Mix fresh blocks,
   // round trips of the previous request and corner blocks.
   task automatic test_random_traffic();
      logic [63:0] key;
      logic [63:0] blk;
      logic        func;
      bit          burst;
      int          gap;
      int          kind;
      for (int p = 0; p < RandomPhases; p++) begin
         wait_drained();
         case (p)
            1:       key = '1;
            3:       key = 64'h1 << $urandom_range(0, 63);
            5:       key = '0;
            default: key = {$urandom, $urandom};
         endcase
         load_key(key);
         // every third phase runs back to back
         burst = (p % 3 == 2);
         for (int n = 0; n < PhaseRequests; n++) begin
            gap  = burst ? 0 : $urandom_range(0, 7);
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
               func = ($urandom_range(0, 1) == 1);
               blk  = {$urandom, $urandom};
            end else if (kind <= 8) begin
               func = ~last_func;
               blk  = last_block_out;
            end else begin
               func = ($urandom_range(0, 1) == 1);
               case ($urandom_range(0, 3))
                  0:       blk = '0;
                  1:       blk = '1;
                  2:       blk = 64'h1 << $urandom_range(0, 63);
                  default: blk = ~(64'h1 << $urandom_range(0, 63));
               endcase
            end
            send_request(func, blk, gap);
            // now and then let the pipeline run dry
            if ($urandom_range(0, 59) == 0) wait_drained();
         end
      end
   endtask

   // ---------------------------------------------------------------
   // Result checker: each strobe matches the oldest expected block
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_blocks.size() == 0) begin
            report_mismatch($sformatf("result %h with none expected", rsp_block_out));
         end else begin
            wanted_block = pending_blocks.pop_front();
            if (rsp_block_out !== wanted_block) begin
               report_mismatch($sformatf("block_out %h, expected %h",
                                         rsp_block_out, wanted_block));
            end
         end
      end
   end

   // Watchdog: count cycles in which no request and no result is accepted
   always @(posedge clock) begin
      if ((start && busy === 1'b0) || rsp_valid === 1'b1) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
         $display("[%0t] watchdog: no progress for %0d cycles", $time, IdleLimit);
         $display("klein64_block_cipher_unit_test: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      expand_key(64'h0);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_key();
      test_key_extremes();
      test_key_change();
      test_random_traffic();
      wait_drained();
      // hold a little longer to catch any stray result strobe
      repeat (Rounds + 4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("klein64_block_cipher_unit_test: done, clean");
      end else begin
         $display("klein64_block_cipher_unit_test: done, errors");
      end
      $finish;
   end

endmodule
